// ----- hdl/chrl_pkg.sv -----
// Shared types and constants for the consistent-hash ring lookup block.
`default_nettype none
package chrl_pkg;

	localparam int KEY_W   = 64;
	localparam int OWNER_W = 8;
	localparam int WORD_W  = 2 * KEY_W + OWNER_W;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_OWN,
		S_SHIFT,
		S_INS,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    load;
		status_t res_status;
		logic    clear;
		logic    srch_rd;
		logic    srch_cmp;
		logic    own_rd;
		logic    own_load;
		logic    shift_step;
		logic    ins_wr;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic search_open;
		logic shift_done;
		logic is_insert;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- hdl/chrl_if.sv -----
// Request and response channel interfaces of the ring lookup block.
`default_nettype none
interface chrl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [63:0] key_hi;
	logic [63:0] key_lo;
	logic [7:0]  owner_in;

	modport source(output valid, action, key_hi, key_lo, owner_in, input ready);
	modport sink(input valid, action, key_hi, key_lo, owner_in, output ready);
endinterface

interface chrl_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] owner_out;
	logic [1:0] status;

	modport source(output valid, owner_out, status, input ready);
	modport sink(input valid, owner_out, status, output ready);
endinterface
`default_nettype wire

// ----- hdl/consistent_hash_ring_lookup_top.sv -----
// Top level of the consistent-hash ring lookup block.
//
//   Channel  Role      Payload
//   req      sink      action, key_hi, key_lo, owner_in
//   rsp      source    owner_out, status
//
// One item at a time. A lookup runs S binary search probes, where S is about log2 of the
// entry count plus one; each probe is a read of the single ring memory port and a 128-bit
// compare, and the owner is read after the last probe. An insert runs the same search, then
// moves entries up one at a time and writes the new point. Clear, unknown, full, empty: no search.
// Reset empties the ring at once; the memory is not swept.
// A result waits in the output register while rsp stalls; the block then holds the next one.
`default_nettype none
module consistent_hash_ring_lookup_top #(
	parameter int RING_SIZE = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	chrl_req_if.sink   req,
	chrl_rsp_if.source rsp
);
	import chrl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	chrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_action(req.action),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	chrl_dp #(
		.RING_SIZE(RING_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.action   (req.action),
		.key_hi   (req.key_hi),
		.key_lo   (req.key_lo),
		.owner_in (req.owner_in),
		.out_ready(rsp.ready),
		.out_valid(rsp.valid),
		.owner_out(rsp.owner_out),
		.status   (rsp.status)
	);
endmodule
`default_nettype wire

// ----- hdl/chrl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module chrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hdl/chrl_dp.sv -----
// Datapath of the ring lookup block: ring memory, search bounds, shifter and result register.
`default_nettype none
module chrl_dp #(
	parameter int RING_SIZE = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire chrl_pkg::cmd_t                    cmd,
	output      chrl_pkg::sts_t                    sts,
	input  wire logic [1:0]                        action,
	input  wire logic [chrl_pkg::KEY_W-1:0]        key_hi,
	input  wire logic [chrl_pkg::KEY_W-1:0]        key_lo,
	input  wire logic [chrl_pkg::OWNER_W-1:0]      owner_in,
	input  wire logic                              out_ready,
	output      logic                              out_valid,
	output      logic [chrl_pkg::OWNER_W-1:0]      owner_out,
	output      logic [1:0]                        status
);
	import chrl_pkg::*;

	localparam int IDX_W = $clog2(RING_SIZE);
	localparam int CNT_W = $clog2(RING_SIZE + 1);

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   first_q;
	logic [CNT_W-1:0]   last_q;
	logic [CNT_W-1:0]   mid_q;
	logic [CNT_W-1:0]   i_q;
	logic               pend_q;
	logic [IDX_W-1:0]   pend_addr_q;
	logic [KEY_W-1:0]   key_hi_q;
	logic [KEY_W-1:0]   key_lo_q;
	logic [OWNER_W-1:0] owner_q;
	logic               is_insert_q;
	logic [OWNER_W-1:0] res_owner_q;
	status_t            res_status_q;
	logic               out_valid_q;
	logic [OWNER_W-1:0] owner_out_q;
	status_t            status_q;

	logic [CNT_W-1:0]   mid;
	logic [IDX_W-1:0]   wrap_idx;
	logic               i_gt_first;
	logic               key_lt_pt;
	logic               pt_lt_key;
	logic               go_right;
	logic [WORD_W-1:0]  rdata;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;

	assign mid        = first_q + ((last_q - first_q) >> 1);
	assign wrap_idx   = (first_q >= count_q) ? '0 : first_q[IDX_W-1:0];
	assign i_gt_first = i_q > first_q;
	assign key_lt_pt  = {key_hi_q, key_lo_q} < rdata[WORD_W-1:OWNER_W];
	assign pt_lt_key  = rdata[WORD_W-1:OWNER_W] < {key_hi_q, key_lo_q};
	assign go_right   = is_insert_q ? !key_lt_pt : pt_lt_key;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = mid[IDX_W-1:0];
		if (cmd.srch_rd) begin
			ram_re = 1'b1;
		end else if (cmd.own_rd) begin
			ram_re    = 1'b1;
			ram_raddr = wrap_idx;
		end else if (cmd.shift_step && i_gt_first) begin
			ram_re    = 1'b1;
			ram_raddr = IDX_W'(i_q - CNT_W'(1));
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pend_addr_q;
		ram_wdata = rdata;
		if (cmd.shift_step && pend_q) begin
			ram_we = 1'b1;
		end else if (cmd.ins_wr) begin
			ram_we    = 1'b1;
			ram_waddr = first_q[IDX_W-1:0];
			ram_wdata = {key_hi_q, key_lo_q, owner_q};
		end
	end

	chrl_ram #(
		.WIDTH(WORD_W),
		.DEPTH(RING_SIZE)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.rdata_q(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.ins_wr) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.load) begin
				pend_q <= 1'b0;
			end else if (cmd.shift_step) begin
				pend_q <= i_gt_first;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			first_q      <= '0;
			last_q       <= count_q;
			i_q          <= count_q;
			key_hi_q     <= key_hi;
			key_lo_q     <= key_lo;
			owner_q      <= owner_in;
			is_insert_q  <= action == ACT_INSERT;
			res_owner_q  <= '0;
			res_status_q <= cmd.res_status;
		end
		if (cmd.srch_rd) begin
			mid_q <= mid;
		end
		if (cmd.srch_cmp) begin
			if (go_right) begin
				first_q <= mid_q + CNT_W'(1);
			end else begin
				last_q <= mid_q;
			end
		end
		if (cmd.own_load) begin
			res_owner_q <= rdata[OWNER_W-1:0];
		end
		if (cmd.shift_step && i_gt_first) begin
			i_q         <= i_q - CNT_W'(1);
			pend_addr_q <= i_q[IDX_W-1:0];
		end
		if (cmd.out_load) begin
			owner_out_q <= res_owner_q;
			status_q    <= res_status_q;
		end
	end

	always_comb begin
		sts             = '0;
		sts.count_zero  = count_q == '0;
		sts.count_full  = count_q == CNT_W'(RING_SIZE);
		sts.search_open = first_q < last_q;
		sts.shift_done  = !pend_q && !i_gt_first;
		sts.is_insert   = is_insert_q;
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign owner_out = owner_out_q;
	assign status    = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RING_SIZE))
		else $error("Entry count exceeds the ring size.");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> count_q < CNT_W'(RING_SIZE))
		else $error("Point written into a full ring.");

	a_own_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.own_rd |-> !sts.count_zero && (CNT_W'(wrap_idx) < count_q))
		else $error("Owner read outside the filled part of the ring.");

	a_mid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_rd |-> (mid < last_q) && (last_q <= count_q))
		else $error("Search probe outside the search window.");
endmodule
`default_nettype wire

// ----- hdl/chrl_ctrl.sv -----
// Controller state machine of the ring lookup block.
`default_nettype none
module chrl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic [1:0]     in_action,
	output      logic           in_ready,
	input  wire chrl_pkg::sts_t sts,
	output      chrl_pkg::cmd_t cmd
);
	import chrl_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_action)
						ACT_INSERT: state_nxt = sts.count_full ? S_RESP : S_SRCH;
						ACT_LOOKUP: state_nxt = sts.count_zero ? S_RESP : S_SRCH;
						default:    state_nxt = S_RESP;
					endcase
				end
			end
			S_SRCH: begin
				if (sts.search_open) begin
					state_nxt = S_CMP;
				end else if (sts.is_insert) begin
					state_nxt = S_SHIFT;
				end else begin
					state_nxt = S_OWN;
				end
			end
			S_CMP:   state_nxt = S_SRCH;
			S_OWN:   state_nxt = S_RESP;
			S_SHIFT: state_nxt = sts.shift_done ? S_INS : S_SHIFT;
			S_INS:   state_nxt = S_RESP;
			S_RESP:  state_nxt = sts.out_free ? S_IDLE : S_RESP;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.clear = in_valid && (in_action == ACT_CLEAR);
				case (in_action)
					ACT_INSERT: cmd.res_status = sts.count_full ? ST_FULL : ST_OK;
					ACT_LOOKUP: cmd.res_status = sts.count_zero ? ST_EMPTY : ST_OK;
					default:    cmd.res_status = ST_OK;
				endcase
			end
			S_SRCH: begin
				cmd.srch_rd = sts.search_open;
				cmd.own_rd  = !sts.search_open && !sts.is_insert;
			end
			S_CMP:   cmd.srch_cmp = 1'b1;
			S_OWN:   cmd.own_load = 1'b1;
			S_SHIFT: cmd.shift_step = 1'b1;
			S_INS:   cmd.ins_wr = 1'b1;
			S_RESP:  cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q != S_IDLE)
		else $error("Accepted item left the controller idle.");

	a_resp_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == S_IDLE)
		else $error("Result loaded without returning to idle.");

	a_shift_ins: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> $past(state_q) == S_SHIFT)
		else $error("Point write without a finished shift.");
endmodule
`default_nettype wire

// ----- bench/ring_lookup_checker.sv -----
// Checker that mirrors the hash ring, predicts each result and compares it with the block.
module ring_lookup_checker (
	input logic clk,
	input logic arst_n,
	chrl_req_if req,
	chrl_rsp_if rsp,
	output int fail_count,
	output int results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import chrl_pkg::*;

	localparam int RING_DEPTH = 1024;

	typedef struct packed {
		logic [127:0] key;
		logic [7:0]   owner;
	} ring_pt_t;

	typedef struct packed {
		logic [7:0] owner;
		status_t    status;
	} ring_res_t;

	ring_pt_t    ring_pts [RING_DEPTH];
	int unsigned ring_count = 0;
	ring_res_t   owed_results[$];

	function automatic ring_res_t ring_apply(logic [1:0] act, logic [127:0] probe,
			logic [7:0] own);
		ring_res_t   res;
		int unsigned pos;
		res.owner = '0;
		res.status = ST_OK;
		case (act)
			ACT_INSERT: begin
				if (ring_count >= RING_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					pos = ring_count;
					while (pos > 0 && ring_pts[pos - 1].key > probe) begin
						ring_pts[pos] = ring_pts[pos - 1];
						pos--;
					end
					ring_pts[pos] = '{key: probe, owner: own};
					ring_count++;
				end
			end
			ACT_LOOKUP: begin
				if (ring_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					pos = 0;
					while (pos < ring_count && ring_pts[pos].key < probe)
						pos++;
					if (pos == ring_count)
						pos = 0;
					res.owner = ring_pts[pos].owner;
				end
			end
			ACT_CLEAR: begin
				ring_count = 0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ring_lookup_checker: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin
		ring_res_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				results_seen <= results_seen + 1;
				if (owed_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result owner %0d status %0d",
						rsp.owner_out, rsp.status));
				end else begin
					want = owed_results.pop_front();
					if (rsp.owner_out !== want.owner)
						report_mismatch($sformatf("owner_out got %0d want %0d",
							rsp.owner_out, want.owner));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							rsp.status, want.status));
				end
			end
			if (req.valid && req.ready)
				owed_results.insert(owed_results.size(),
					ring_apply(req.action, {req.key_hi, req.key_lo}, req.owner_in));
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// Top of the ring lookup testbench: clock, reset, stimulus, response stalls and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import chrl_pkg::*;

	localparam logic [1:0] ACT_UNKNOWN = 2'd3;
	localparam int RING_DEPTH   = 1024;
	localparam int SMALL_ITEMS  = 40;
	localparam int IDLE_LIMIT   = 20000;
	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_START   = 300;
	localparam int HOLD_LEN     = 400;
	localparam logic [127:0] MID_KEY = {64'h8000_0000_0000_0000, 64'd0};

	logic clk;
	logic arst_n;
	int   fails;
	int   results_seen;
	int   items_sent = 0;
	int   burst_left = 0;
	logic [127:0] live_keys[$];

	chrl_req_if req_ch();
	chrl_rsp_if rsp_ch();

	consistent_hash_ring_lookup_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	ring_lookup_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fails),
		.results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [127:0] rand_key();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return {56'd0, 8'($urandom_range(0, 3)), $urandom, $urandom};
			default: return {$urandom, $urandom, $urandom, $urandom};
		endcase
	endfunction

	function automatic logic [127:0] near_key();
		logic [127:0] k;
		if (live_keys.size() == 0)
			return rand_key();
		k = live_keys[$urandom_range(0, live_keys.size() - 1)];
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return k;
			4: return k + 128'd1;
			5: return k - 128'd1;
			8: return '0;
			9: return '1;
			default: return rand_key();
		endcase
	endfunction

	task automatic send_item(input logic [1:0] act, input logic [127:0] probe,
			input logic [7:0] own);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.key_hi <= probe[127:64];
		req_ch.key_lo <= probe[63:0];
		req_ch.owner_in <= own;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
		items_sent++;
		if (act == ACT_INSERT && live_keys.size() < RING_DEPTH)
			live_keys.insert(live_keys.size(), probe);
		else if (act == ACT_CLEAR)
			live_keys.delete();
	endtask

	initial begin
		int small_end;
		int n;
		int r;
		logic [127:0] asc_key;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_INSERT;
		req_ch.key_hi <= '0;
		req_ch.key_lo <= '0;
		req_ch.owner_in <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(ACT_LOOKUP, '1, 8'hFF);
		send_item(ACT_UNKNOWN, '1, 8'hFF);
		send_item(ACT_CLEAR, '1, 8'hFF);
		send_item(ACT_INSERT, '0, 8'hFF);
		send_item(ACT_INSERT, '1, 8'h00);
		send_item(ACT_INSERT, MID_KEY, 8'h5A);
		send_item(ACT_INSERT, MID_KEY, 8'hA5);
		send_item(ACT_INSERT, {64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF}, 8'h33);
		send_item(ACT_INSERT, {64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 8'h11);
		send_item(ACT_LOOKUP, '0, 8'hC3);
		send_item(ACT_LOOKUP, 128'd1, 8'hC3);
		send_item(ACT_LOOKUP, MID_KEY, 8'hC3);
		send_item(ACT_LOOKUP, MID_KEY + 128'd1, 8'hC3);
		send_item(ACT_LOOKUP, MID_KEY - 128'd1, 8'h3C);
		send_item(ACT_LOOKUP, '1, 8'h3C);
		send_item(ACT_UNKNOWN, '0, 8'h00);
		send_item(ACT_LOOKUP, {64'h8000_0000_0000_0001, 64'd0}, 8'h00);
		send_item(ACT_CLEAR, '0, 8'h00);
		send_item(ACT_LOOKUP, MID_KEY, 8'h00);
		send_item(ACT_INSERT, {64'd1, 64'd0}, 8'h42);
		send_item(ACT_LOOKUP, '1, 8'h00);
		send_item(ACT_LOOKUP, '0, 8'h00);

		small_end = items_sent + SMALL_ITEMS;
		while (items_sent < small_end) begin
			if ($urandom_range(0, 3) != 0)
				send_item(ACT_CLEAR, rand_key(), 8'($urandom));
			if ($urandom_range(0, 3) == 0)
				send_item(ACT_LOOKUP, near_key(), 8'($urandom));
			n = $urandom_range(1, 16);
			repeat (n) begin
				if ($urandom_range(0, 2) == 0)
					send_item(ACT_LOOKUP, near_key(), 8'($urandom));
				if ($urandom_range(0, 19) == 0)
					send_item(ACT_UNKNOWN, rand_key(), 8'($urandom));
				send_item(ACT_INSERT, ($urandom_range(0, 1) == 0) ? near_key() : rand_key(),
					8'($urandom));
			end
			repeat ($urandom_range(2, 10))
				send_item(ACT_LOOKUP, near_key(), 8'($urandom));
		end

		// Fill the ring to capacity, mostly in ascending order to keep inserts short.
		send_item(ACT_CLEAR, '0, 8'($urandom));
		asc_key = '0;
		while (live_keys.size() < RING_DEPTH) begin
			r = $urandom_range(0, 19);
			if (r == 0) begin
				send_item(ACT_LOOKUP, near_key(), 8'($urandom));
			end else if (r < 5) begin
				send_item(ACT_INSERT, rand_key(), 8'($urandom));
			end else if (r == 5) begin
				send_item(ACT_INSERT, asc_key, 8'($urandom));
			end else begin
				asc_key = asc_key + {42'd0, 22'($urandom_range(0, 1 << 22)), $urandom, $urandom};
				send_item(ACT_INSERT, asc_key, 8'($urandom));
			end
		end
		repeat (6)
			send_item(ACT_INSERT, rand_key(), 8'($urandom));
		repeat (25)
			send_item(ACT_LOOKUP, near_key(), 8'($urandom));
		send_item(ACT_UNKNOWN, rand_key(), 8'($urandom));
		send_item(ACT_INSERT, '0, 8'($urandom));
		send_item(ACT_LOOKUP, '1, 8'($urandom));
		send_item(ACT_CLEAR, rand_key(), 8'($urandom));
		send_item(ACT_LOOKUP, rand_key(), 8'($urandom));
		send_item(ACT_INSERT, rand_key(), 8'($urandom));
		send_item(ACT_LOOKUP, near_key(), 8'($urandom));
		req_ch.valid <= 1'b0;

		while (results_seen < items_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		int mode;
		int span;
		int cyc;
		int hold_left;
		bit held;
		cyc = 0;
		hold_left = 0;
		held = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 150);
			repeat (span) begin
				@(posedge clk);
				cyc++;
				if (!held && cyc >= HOLD_START) begin
					held = 1'b1;
					hold_left = HOLD_LEN;
				end
				if (hold_left != 0) begin
					rsp_ch.ready <= 1'b0;
					hold_left--;
				end else begin
					case (mode)
						0: rsp_ch.ready <= 1'b1;
						1: rsp_ch.ready <= 1'($urandom_range(0, 1));
						2: rsp_ch.ready <= (cyc % 4 == 0);
						default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
					endcase
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_top: errors");
		$finish;
	end

endmodule
